// ===== design/rot_pkg.sv =====
// ----------------------------------------------------------------------------
// rot_pkg - rectangle overlap table shared definitions
// Field widths, operation codes, the stored entry layout, the control bundle
// that steers the cell chain, and the overlap test.
// ----------------------------------------------------------------------------
package rot_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int MODE_W           = 2;
    localparam int TAG_W            = 16;
    localparam int COORD_W          = 16;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_COMPACT,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic               side;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
    } rect_t;

    typedef struct packed {
        logic  occ;
        rect_t rect;
    } entry_t;

    typedef struct packed {
        logic cmp_load;  // capture the overlap result against the probe
        logic clear;     // empty every cell
        logic del_mark;  // drop cells whose tag matches the probe
        logic shift_in;  // every cell takes its newer neighbour's entry
        logic compact;   // cells at or behind the first hole take the next entry
    } cell_ctrl_t;

    // Half-open extents overlap on both axes.
    function automatic logic overlaps(input rect_t a, input rect_t b);
        logic ox;
        logic oy;
        ox = (a.min_x < b.max_x) && (b.min_x < a.max_x);
        oy = (a.min_y < b.max_y) && (b.min_y < a.max_y);
        return ox && oy;
    endfunction

endpackage

// ===== design/rot_in_if.sv =====
// ----------------------------------------------------------------------------
// rot_in_if - request channel of the rectangle overlap table
// Valid/ready handshake carrying one operation item.
// ----------------------------------------------------------------------------
interface rot_in_if;

    logic                        valid;
    logic                        ready;
    logic [rot_pkg::MODE_W-1:0]  mode;
    logic [rot_pkg::TAG_W-1:0]   tag;
    logic [rot_pkg::COORD_W-1:0] min_x;
    logic [rot_pkg::COORD_W-1:0] min_y;
    logic [rot_pkg::COORD_W-1:0] max_x;
    logic [rot_pkg::COORD_W-1:0] max_y;
    logic                        side;
    logic                        ignore;

    modport source (
        output valid, mode, tag, min_x, min_y, max_x, max_y, side, ignore,
        input  ready
    );

    modport sink (
        input  valid, mode, tag, min_x, min_y, max_x, max_y, side, ignore,
        output ready
    );

endinterface

// ===== design/rot_out_if.sv =====
// ----------------------------------------------------------------------------
// rot_out_if - result channel of the rectangle overlap table
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface rot_out_if;

    logic                      valid;
    logic                      ready;
    logic                      conflict;
    logic [rot_pkg::TAG_W-1:0] conflict_tag;
    logic                      stored;
    logic                      full_res;

    modport source (
        output valid, conflict, conflict_tag, stored, full_res,
        input  ready
    );

    modport sink (
        input  valid, conflict, conflict_tag, stored, full_res,
        output ready
    );

endinterface

// ===== design/rot_prefix.sv =====
// ----------------------------------------------------------------------------
// rot_prefix - inclusive prefix OR across the cell chain
// Log-depth parallel prefix: bit i of the result is the OR of bits 0..i.
// ----------------------------------------------------------------------------
module rot_prefix #(
    parameter int N = rot_pkg::DEFAULT_CAPACITY
) (
    input  logic [N-1:0] bits,
    output logic [N-1:0] prefix
);

    localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [LEVELS+1];

    assign lvl[0] = bits;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        for (genvar i = 0; i < N; i++)
        begin : g_bit
            if (i >= (1 << l))
            begin : g_merge
                assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
            end
            else
            begin : g_pass
                assign lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    assign prefix = lvl[LEVELS];

endmodule

// ===== design/rot_cell.sv =====
// ----------------------------------------------------------------------------
// rot_cell - one slot of the rectangle overlap table
// Holds one entry, tests it against the probe rectangle, and takes its
// neighbour's entry on insert shifts and on compaction steps.
// ----------------------------------------------------------------------------
module rot_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  rot_pkg::cell_ctrl_t ctrl,
    input  rot_pkg::rect_t      probe,
    input  logic                take,
    input  rot_pkg::entry_t     prev,
    input  rot_pkg::entry_t     next,
    output rot_pkg::entry_t     entry,
    output logic                hit
);

    logic           occ_reg;
    logic           occ_next;
    rot_pkg::rect_t rect_reg;
    rot_pkg::rect_t rect_next;
    logic           hit_reg;
    logic           hit_next;

    always_comb
    begin
        occ_next  = occ_reg;
        rect_next = rect_reg;
        if (ctrl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (ctrl.del_mark)
        begin
            if (occ_reg && (rect_reg.tag == probe.tag))
            begin
                occ_next = 1'b0;
            end
        end
        else if (ctrl.shift_in)
        begin
            occ_next  = prev.occ;
            rect_next = prev.rect;
        end
        else if (ctrl.compact && take)
        begin
            occ_next  = next.occ;
            rect_next = next.rect;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.cmp_load)
        begin
            hit_next = occ_reg && (rect_reg.side == probe.side) &&
                       rot_pkg::overlaps(rect_reg, probe);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
    end

    assign entry.occ  = occ_reg;
    assign entry.rect = rect_reg;
    assign hit        = hit_reg;

endmodule

// ===== design/rectangle_overlap_table_unit.sv =====
// ----------------------------------------------------------------------------
// rectangle_overlap_table_unit - table of placed rectangles with overlap check
// Usage: items arrive on req (valid/ready) and each gives exactly one result
// item on rsp (valid/ready). Entries sit in a chain of cells, newest in cell 0.
// Insert: every cell compares against the item in the accept cycle; then
// the insert state picks the newest same-side overlap, or shifts the chain
// by one to store the rectangle, or reports full when the last cell is
// taken. Delete drops matching cells at accept, then closes one hole per
// cycle (prefix OR over empty cells) until the live entries are packed.
// Clear, ignored insert and the unused mode go straight to the reply state.
// req.ready is high only while no item is in progress; a finished result
// waiting in the output register does not block acceptance of the next
// item, but that item holds in its final cycle until rsp is free.
// Reset empties the table at once (occupancy flags) and drops any result.
// ----------------------------------------------------------------------------
module rectangle_overlap_table_unit #(
    parameter int CAPACITY = rot_pkg::DEFAULT_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    rot_in_if.sink    req,
    rot_out_if.source rsp
);

    rot_pkg::state_t     state_reg;
    rot_pkg::state_t     state_next;
    rot_pkg::cell_ctrl_t ctrl;
    rot_pkg::rect_t      probe;
    rot_pkg::rect_t      new_reg;
    rot_pkg::entry_t     new_entry;

    rot_pkg::entry_t ent      [CAPACITY];
    rot_pkg::entry_t ent_prev [CAPACITY];
    rot_pkg::entry_t ent_next [CAPACITY];

    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] hits;
    logic [CAPACITY-1:0] take;
    logic [CAPACITY-1:0] hit_pre;
    logic [CAPACITY-1:0] first_hit;

    logic                      accept;
    logic                      out_free;
    logic                      hole_any;
    logic                      conflict_any;
    logic                      full;
    logic [rot_pkg::TAG_W-1:0] ctag;
    logic                      load_out;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      conflict_reg;
    logic                      conflict_next;
    logic [rot_pkg::TAG_W-1:0] ctag_reg;
    logic [rot_pkg::TAG_W-1:0] ctag_next;
    logic                      stored_reg;
    logic                      stored_next;
    logic                      full_reg;
    logic                      full_next;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign probe.side  = req.side;
    assign probe.tag   = req.tag;
    assign probe.min_x = req.min_x;
    assign probe.min_y = req.min_y;
    assign probe.max_x = req.max_x;
    assign probe.max_y = req.max_y;

    assign new_entry.occ  = 1'b1;
    assign new_entry.rect = new_reg;

    // Hold the item for the insert shift.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_reg <= probe;
        end
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign ent_prev[i] = new_entry;
        end
        else
        begin : g_body
            assign ent_prev[i] = ent[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign ent_next[i] = '0;
        end
        else
        begin : g_link
            assign ent_next[i] = ent[i+1];
        end

        rot_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .probe (probe),
            .take  (take[i]),
            .prev  (ent_prev[i]),
            .next  (ent_next[i]),
            .entry (ent[i]),
            .hit   (hits[i])
        );

        assign occ[i] = ent[i].occ;
    end

    // Cells at or behind the first hole advance by one on a compaction step.
    rot_prefix #(
        .N (CAPACITY)
    ) u_hole_prefix (
        .bits   (~occ),
        .prefix (take)
    );

    assign hole_any = |(~occ[CAPACITY-2:0] & occ[CAPACITY-1:1]);
    assign full     = occ[CAPACITY-1];

    // Newest overlap is the lowest-numbered hit.
    rot_prefix #(
        .N (CAPACITY)
    ) u_hit_prefix (
        .bits   (hits),
        .prefix (hit_pre)
    );

    assign first_hit[0]            = hits[0];
    assign first_hit[CAPACITY-1:1] = hits[CAPACITY-1:1] & ~hit_pre[CAPACITY-2:0];
    assign conflict_any            = hit_pre[CAPACITY-1];

    always_comb
    begin
        ctag = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hit[i])
            begin
                ctag = ctag | ent[i].rect.tag;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rot_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.mode == rot_pkg::MODE_INSERT) && !req.ignore)
                    begin
                        state_next = rot_pkg::ST_INSERT;
                    end
                    else if (req.mode == rot_pkg::MODE_DELETE)
                    begin
                        state_next = rot_pkg::ST_COMPACT;
                    end
                    else
                    begin
                        state_next = rot_pkg::ST_REPLY;
                    end
                end
            end
            rot_pkg::ST_INSERT,
            rot_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = rot_pkg::ST_IDLE;
                end
            end
            rot_pkg::ST_COMPACT:
            begin
                if (!hole_any && out_free)
                begin
                    state_next = rot_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rot_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req.ready     = 1'b0;
        ctrl          = '0;
        load_out      = 1'b0;
        conflict_next = 1'b0;
        ctag_next     = '0;
        stored_next   = 1'b0;
        full_next     = 1'b0;
        ctrl.cmp_load = accept;
        ctrl.clear    = accept && (req.mode == rot_pkg::MODE_CLEAR);
        ctrl.del_mark = accept && (req.mode == rot_pkg::MODE_DELETE);
        unique case (state_reg)
            rot_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            rot_pkg::ST_INSERT:
            begin
                load_out      = out_free;
                ctrl.shift_in = out_free && !conflict_any && !full;
                conflict_next = conflict_any;
                ctag_next     = ctag;
                stored_next   = !conflict_any && !full;
                full_next     = !conflict_any && full;
            end
            rot_pkg::ST_COMPACT:
            begin
                ctrl.compact = hole_any;
                load_out     = !hole_any && out_free;
            end
            rot_pkg::ST_REPLY:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rot_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            conflict_reg <= conflict_next;
            ctag_reg     <= ctag_next;
            stored_reg   <= stored_next;
            full_reg     <= full_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.conflict     = conflict_reg;
    assign rsp.conflict_tag = ctag_reg;
    assign rsp.stored       = stored_reg;
    assign rsp.full_res     = full_reg;

    // The occupied cells stay a packed prefix outside compaction.
    a_packed_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != rot_pkg::ST_COMPACT) |-> !hole_any
    ) else $error("hole in occupied cells outside compaction");

    // A shift never pushes a live entry off the end of the chain.
    a_no_shift_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.shift_in |-> !full
    ) else $error("insert shift with last cell occupied");

    // A stored insert lands in cell 0 on the next cycle.
    a_shift_lands_head: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctrl.shift_in |=> occ[0]
    ) else $error("insert shift left cell 0 empty");

    // Result flags are mutually exclusive and the tag is zero without conflict.
    a_result_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (!(rsp.conflict && rsp.stored) &&
                       !(rsp.stored && rsp.full_res) &&
                       !(rsp.conflict && rsp.full_res) &&
                       (rsp.conflict || (rsp.conflict_tag == '0)))
    ) else $error("inconsistent result item");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - rectangle overlap table unit
// Drives insert, delete, clear and spare-mode items through the request
// channel and checks every result item against a packed-table predictor
// kept here. A short directed table comes first, then random items in four
// phases of sender idling and receiver stalling, two of which fill the table.
// ----------------------------------------------------------------------------
module testbench;

    import rot_pkg::*;

    localparam int TABLE_DEPTH   = DEFAULT_CAPACITY;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
    localparam int IDLE_LIMIT    = 4000;
    localparam int OPENING_ROWS  = 22;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        rect_t             body;
        logic              ignore;
    } request_t;

    typedef struct packed {
        logic             conflict;
        logic [TAG_W-1:0] conflict_tag;
        logic             stored;
        logic             full_res;
    } verdict_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TAG_W-1:0]   tag;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic               side;
        logic               ignore;
        logic               fixed;
        logic               conflict;
        logic [TAG_W-1:0]   conflict_tag;
        logic               stored;
        logic               full_res;
    } opening_row_t;

    // mode, tag, min_x, min_y, max_x, max_y, side, ignore,
    // fixed, conflict, conflict_tag, stored, full_res
    opening_row_t opening_plan [OPENING_ROWS] = '{
        '{MODE_INSERT, 'h0001, 0, 0, 10, 10, 0, 0, 1, 0, 0, 1, 0},
        '{MODE_INSERT, 'h0002, 5, 5, 15, 15, 0, 0, 1, 1, 'h0001, 0, 0},
        '{MODE_INSERT, 'h0003, 5, 5, 15, 15, 1, 0, 1, 0, 0, 1, 0},
        '{MODE_INSERT, 'h0004, 10, 0, 20, 10, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0009, 0, 0, 20, 20, 0, 1, 1, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0005, 20, 20, 5, 5, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0006, 30, 30, 30, 40, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'hFFFF, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'hFFFF, 'hFFFE, 'hFFFE, 'hFFFF, 'hFFFF, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0000, 0, 10, 10, 20, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_DELETE, 'h1234, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 1, 1, 0, 0, 0, 0},
        '{MODE_DELETE, 'h0001, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0007, 2, 2, 3, 3, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0008, 2, 2, 4, 4, 0, 0, 1, 1, 'h0007, 0, 0},
        '{MODE_SPARE, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 1, 1, 0, 0, 0, 0},
        '{MODE_INSERT, 'hA5A5, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_DELETE, 'hFFFF, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{MODE_INSERT, 'h5A5A, 'hFFF0, 'hFFF0, 'hFFFF, 'hFFFF, 1, 0, 0, 0, 0, 0, 0},
        '{MODE_CLEAR, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 1, 1, 0, 0, 0, 0},
        '{MODE_INSERT, 'h0001, 0, 0, 10, 10, 0, 0, 1, 0, 0, 1, 0},
        '{MODE_INSERT, 'h0002, 0, 0, 10, 10, 0, 1, 1, 0, 0, 0, 0},
        '{MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0}
    };

    logic clk;
    logic rst_n;

    rot_in_if  req ();
    rot_out_if rsp ();

    rectangle_overlap_table_unit #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rect_t    placed_rects [$];
    verdict_t pending_verdicts [$];
    int       failures    = 0;
    int       gap_pct     = 0;
    int       stall_pct   = 0;
    int       idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic rects_cross(input rect_t a, input rect_t b);
        if (a.min_x >= b.max_x || b.min_x >= a.max_x)
            return 1'b0;
        return (a.min_y < b.max_y) && (b.min_y < a.max_y);
    endfunction

    // Apply one item to the predicted table and return the result it gives.
    function automatic verdict_t settle_request(input request_t op);
        verdict_t v;
        rect_t    kept [$];
        v = '0;
        case (op.mode)
            MODE_INSERT:
            begin
                if (!op.ignore)
                begin
                    // scan oldest first so the newest overlap wins
                    foreach (placed_rects[i])
                    begin
                        if (placed_rects[i].side == op.body.side &&
                            rects_cross(placed_rects[i], op.body))
                        begin
                            v.conflict     = 1'b1;
                            v.conflict_tag = placed_rects[i].tag;
                        end
                    end
                    if (!v.conflict)
                    begin
                        if (placed_rects.size() < TABLE_DEPTH)
                        begin
                            placed_rects.push_back(op.body);
                            v.stored = 1'b1;
                        end
                        else
                            v.full_res = 1'b1;
                    end
                end
            end
            MODE_DELETE:
            begin
                foreach (placed_rects[i])
                    if (placed_rects[i].tag != op.body.tag)
                        kept.push_back(placed_rects[i]);
                placed_rects = kept;
            end
            MODE_CLEAR:
                placed_rects.delete();
            default:
                ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        failures++;
    endtask

    task automatic hand_over(input request_t op);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.mode   <= op.mode;
        req.tag    <= op.body.tag;
        req.min_x  <= op.body.min_x;
        req.min_y  <= op.body.min_y;
        req.max_x  <= op.body.max_x;
        req.max_y  <= op.body.max_y;
        req.side   <= op.body.side;
        req.ignore <= op.ignore;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic issue(input request_t op);
        hand_over(op);
        pending_verdicts.push_back(settle_request(op));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic void random_span(output logic [COORD_W-1:0] lo,
                                        output logic [COORD_W-1:0] hi);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            lo = COORD_W'($urandom_range(0, 1000));
            hi = COORD_W'(lo + $urandom_range(1, 80));
        end
        else if (pick < 85)
        begin
            lo = COORD_W'($urandom);
            hi = COORD_W'($urandom);
        end
        else
        begin
            // empty or inverted extent
            lo = COORD_W'($urandom);
            hi = COORD_W'(lo - $urandom_range(0, 4));
        end
    endfunction

    function automatic request_t random_request();
        request_t op;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 78)
            op.mode = MODE_INSERT;
        else if (pick < 94)
            op.mode = MODE_DELETE;
        else if (pick < 97)
            op.mode = MODE_CLEAR;
        else
            op.mode = MODE_SPARE;
        // small tag pool so deletes hit and tags repeat
        if ($urandom_range(99) < 80)
            op.body.tag = TAG_W'($urandom_range(0, 15));
        else
            op.body.tag = TAG_W'($urandom);
        random_span(op.body.min_x, op.body.max_x);
        random_span(op.body.min_y, op.body.max_y);
        op.body.side = 1'($urandom_range(1));
        op.ignore    = ($urandom_range(99) < 10);
        return op;
    endfunction

    // Clear, lay disjoint tiles two past capacity, probe, delete one tag.
    task automatic fill_to_capacity();
        request_t tile;
        request_t probe;
        tile      = '0;
        tile.mode = MODE_CLEAR;
        issue(tile);
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
        begin
            tile.mode         = MODE_INSERT;
            tile.ignore       = 1'b0;
            tile.body.side    = 1'($urandom_range(1));
            tile.body.tag     = TAG_W'(16'h0100 + (i % 8));
            tile.body.min_x   = COORD_W'(i * 64 + $urandom_range(0, 20));
            tile.body.max_x   = COORD_W'(tile.body.min_x + $urandom_range(1, 40));
            tile.body.min_y   = COORD_W'($urandom_range(0, 500));
            tile.body.max_y   = COORD_W'(tile.body.min_y + $urandom_range(1, 200));
            if (i == 10)
                probe = tile;
            issue(tile);
        end
        // overlap on a full table still reports its owner
        probe.body.tag = TAG_W'($urandom);
        issue(probe);
        tile.mode     = MODE_DELETE;
        tile.body.tag = 16'h0102;
        issue(tile);
    endtask

    // Result receiver: stall at the phase rate.
    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unrequested result, conflict_tag", rsp.conflict_tag, '0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (rsp.conflict !== want.conflict)
                    report_mismatch("conflict", 16'(rsp.conflict), 16'(want.conflict));
                if (rsp.conflict_tag !== want.conflict_tag)
                    report_mismatch("conflict_tag", rsp.conflict_tag, want.conflict_tag);
                if (rsp.stored !== want.stored)
                    report_mismatch("stored", 16'(rsp.stored), 16'(want.stored));
                if (rsp.full_res !== want.full_res)
                    report_mismatch("full_res", 16'(rsp.full_res), 16'(want.full_res));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        request_t op;
        verdict_t v;
        int       first;
        rst_n      <= 1'b0;
        req.valid  <= 1'b0;
        req.mode   <= MODE_INSERT;
        req.tag    <= '0;
        req.min_x  <= '0;
        req.min_y  <= '0;
        req.max_x  <= '0;
        req.max_y  <= '0;
        req.side   <= 1'b0;
        req.ignore <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_plan[i])
        begin
            op.mode         = opening_plan[i].mode;
            op.body.tag     = opening_plan[i].tag;
            op.body.min_x   = opening_plan[i].min_x;
            op.body.min_y   = opening_plan[i].min_y;
            op.body.max_x   = opening_plan[i].max_x;
            op.body.max_y   = opening_plan[i].max_y;
            op.body.side    = opening_plan[i].side;
            op.ignore       = opening_plan[i].ignore;
            hand_over(op);
            v = settle_request(op);
            if (opening_plan[i].fixed)
            begin
                v.conflict     = opening_plan[i].conflict;
                v.conflict_tag = opening_plan[i].conflict_tag;
                v.stored       = opening_plan[i].stored;
                v.full_res     = opening_plan[i].full_res;
            end
            pending_verdicts.push_back(v);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold the sender until every result is back
            drain();
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase
            first = 0;
            if (phase % 2 == 1)
            begin
                fill_to_capacity();
                first = TABLE_DEPTH + 5;
            end
            for (int n = first; n < PHASE_ITEMS; n++)
                issue(random_request());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/rot_pkg.sv
design/rot_in_if.sv
design/rot_out_if.sv
design/rot_prefix.sv
design/rot_cell.sv
design/rectangle_overlap_table_unit.sv
test/testbench.sv
